// ----- hdl/bvp_pkg.sv -----
package bvp_pkg;

  // voltage/percent table: both columns rise strictly
  localparam int TABLE_POINTS = 11;
  localparam int SEGMENTS     = TABLE_POINTS - 1;
  localparam int SEG_W        = $clog2(SEGMENTS);

  localparam int VOLT_W   = 16;
  localparam int TAB_V_W  = 13;
  localparam int DEN_W    = 8;
  localparam int PCT_W    = 7;
  localparam int PCT_STEP = 10;

  localparam int DIGITS_W = 3;
  localparam int THR_W    = 7;
  localparam int SCALE_W  = 14;
  localparam int TEN_M_W  = 17;
  localparam int OUT_W    = 20;

  // quotient by reciprocal: num < 2**RECIP_SHIFT keeps the estimate within one
  localparam int NUM_W       = 25;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int QUO_W       = 17;
  localparam int P1M_W       = 20;
  localparam int BACK_W      = QUO_W + DEN_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 3'd0;
  localparam logic [THR_W-1:0]    THR_RESET    = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRACTION_DIGITS = 1'd0,
    REG_EMPTY_THRESHOLD = 1'd1
  } cfg_reg_e;

  localparam logic [TAB_V_W-1:0] VOLT_TAB [TABLE_POINTS] = '{
    13'd3000, 13'd3200, 13'd3400, 13'd3560, 13'd3680, 13'd3800,
    13'd3880, 13'd3960, 13'd4040, 13'd4120, 13'd4200
  };

  localparam logic [PCT_W-1:0] PCT_TAB [TABLE_POINTS] = '{
    7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  // segment widths v2 - v1
  localparam logic [DEN_W-1:0] DEN_TAB [SEGMENTS] = '{
    8'd200, 8'd200, 8'd160, 8'd120, 8'd120, 8'd80, 8'd80, 8'd80, 8'd80, 8'd80
  };

  localparam logic [RECIP_W-1:0] RECIP_TAB [SEGMENTS] = '{
    RECIP_W'((2 ** RECIP_SHIFT) / 200), RECIP_W'((2 ** RECIP_SHIFT) / 200),
    RECIP_W'((2 ** RECIP_SHIFT) / 160), RECIP_W'((2 ** RECIP_SHIFT) / 120),
    RECIP_W'((2 ** RECIP_SHIFT) / 120), RECIP_W'((2 ** RECIP_SHIFT) / 80),
    RECIP_W'((2 ** RECIP_SHIFT) / 80),  RECIP_W'((2 ** RECIP_SHIFT) / 80),
    RECIP_W'((2 ** RECIP_SHIFT) / 80),  RECIP_W'((2 ** RECIP_SHIFT) / 80)
  };

  // digit counts above four saturate
  localparam logic [SCALE_W-1:0] SCALE_TAB [2 ** DIGITS_W] = '{
    14'd1, 14'd10, 14'd100, 14'd1000, 14'd10000, 14'd10000, 14'd10000, 14'd10000
  };

  localparam logic [TEN_M_W-1:0] TEN_M_TAB [2 ** DIGITS_W] = '{
    17'd10, 17'd100, 17'd1000, 17'd10000,
    17'd100000, 17'd100000, 17'd100000, 17'd100000
  };

  localparam logic [OUT_W-1:0] HUNDRED_M_TAB [2 ** DIGITS_W] = '{
    20'd100, 20'd1000, 20'd10000, 20'd100000,
    20'd1000000, 20'd1000000, 20'd1000000, 20'd1000000
  };

  typedef struct packed {
    logic             sat_lo;
    logic             sat_hi;
    logic [SEG_W-1:0] seg;
    logic [DEN_W-1:0] dv;
  } dec_t;

  typedef struct packed {
    logic             sat_lo;
    logic             sat_hi;
    logic [SEG_W-1:0] seg;
    logic [NUM_W-1:0] num;
    logic [P1M_W-1:0] p1m;
    logic [PCT_W-1:0] whole;
  } scl_t;

  typedef struct packed {
    logic             sat_lo;
    logic             sat_hi;
    logic [P1M_W-1:0] p1m;
    logic [PCT_W-1:0] whole;
  } tail_t;

endpackage

// ----- hdl/battery_voltage_to_percent.sv -----
// Channel  | Ports                                   | Direction | Beat taken when
// ---------+-----------------------------------------+-----------+--------------------
// sample   | start_i, busy_o, voltage_mv_i           | in        | start_i && !busy_o
// result   | done_o, percent_scaled_o, is_empty_o    | out       | done_o (one cycle)
// config   | cfg_we_i, cfg_idx_i, cfg_data_i         | in        | cfg_we_i
//
// One sample is taken every cycle; busy_o stays low. Each result passes through
// five registered stages: segment decode, scaling multiplies, reciprocal
// multiply, back-multiply, then correction and output register.
// The sustained rate of one beat per cycle is set by the five-stage multiplier
// pipeline, which has no feedback. Reset clears the valid bits of every stage
// and loads the configuration registers with their reset values. The receiver
// cannot stall, so the pipeline always advances.
module battery_voltage_to_percent (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [bvp_pkg::VOLT_W-1:0]     voltage_mv_i,
  output logic                           done_o,
  output logic [bvp_pkg::OUT_W-1:0]      percent_scaled_o,
  output logic                           is_empty_o,
  input  logic                           cfg_we_i,
  input  logic [bvp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bvp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LATENCY = 5;

  // configuration registers
  logic [bvp_pkg::DIGITS_W-1:0] digits_q;
  logic [bvp_pkg::THR_W-1:0]    thr_q;

  logic                         in_valid;
  logic                         dec_valid, scl_valid, quo_valid;
  bvp_pkg::dec_t                dec;
  bvp_pkg::scl_t                scl;
  logic [bvp_pkg::QUO_W-1:0]    quo;
  bvp_pkg::tail_t               tail;

  logic [bvp_pkg::OUT_W-1:0]    res_d, res_q;
  logic                         empty_d, empty_q;
  logic                         done_q;

  // never holds a sample off
  assign busy_o   = 1'b0;
  assign in_valid = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= bvp_pkg::DIGITS_RESET;
      thr_q    <= bvp_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bvp_pkg::REG_FRACTION_DIGITS: digits_q <= cfg_data_i[bvp_pkg::DIGITS_W-1:0];
        bvp_pkg::REG_EMPTY_THRESHOLD: thr_q    <= cfg_data_i[bvp_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  bvp_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .voltage_mv_i (voltage_mv_i),
    .dec_valid_o  (dec_valid),
    .dec_o        (dec)
  );

  bvp_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (dec_valid),
    .dec_i       (dec),
    .digits_i    (digits_q),
    .scl_valid_o (scl_valid),
    .scl_o       (scl)
  );

  bvp_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scl_valid_i (scl_valid),
    .scl_i       (scl),
    .quo_valid_o (quo_valid),
    .quo_o       (quo),
    .tail_o      (tail)
  );

  // Output stage: saturation at either end of the table, else quotient plus
  // the scaled base percent of the segment.
  always_comb begin
    if (tail.sat_lo) begin
      res_d = '0;
    end else if (tail.sat_hi) begin
      res_d = bvp_pkg::HUNDRED_M_TAB[digits_q];
    end else begin
      res_d = bvp_pkg::OUT_W'(quo) + tail.p1m;
    end
    // thresholds above one hundred simply always flag empty
    empty_d = tail.whole < thr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= quo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quo_valid) begin
      res_q   <= res_d;
      empty_q <= empty_d;
    end
  end

  assign done_o           = done_q;
  assign percent_scaled_o = res_q;
  assign is_empty_o       = empty_q;

  // every sample beat comes out exactly once, a fixed latency later
  a_sample_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid |-> ##LATENCY done_o)
    else $error("sample beat produced no result");

  a_result_had_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid, LATENCY))
    else $error("result beat without a sample");

  // a zero result means a whole percent of zero
  a_zero_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && percent_scaled_o == '0) |-> (is_empty_o == ($past(thr_q) != '0)))
    else $error("empty flag disagrees with zero result");

endmodule

// ----- hdl/bvp_decode.sv -----
// Stage 1: segment search and offset into the segment
module bvp_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [bvp_pkg::VOLT_W-1:0] voltage_mv_i,
  output logic                       dec_valid_o,
  output bvp_pkg::dec_t              dec_o
);

  localparam int PAD_W = bvp_pkg::VOLT_W - bvp_pkg::TAB_V_W;

  bvp_pkg::dec_t              dec_d, dec_q;
  logic                       valid_q;
  logic [bvp_pkg::VOLT_W-1:0] diff;

  always_comb begin
    dec_d.sat_lo = voltage_mv_i <= {{PAD_W{1'b0}}, bvp_pkg::VOLT_TAB[0]};
    dec_d.sat_hi = voltage_mv_i >=
                   {{PAD_W{1'b0}}, bvp_pkg::VOLT_TAB[bvp_pkg::TABLE_POINTS-1]};
    dec_d.seg    = '0;
    for (int i = 0; i < bvp_pkg::SEGMENTS; i++) begin
      if (voltage_mv_i > {{PAD_W{1'b0}}, bvp_pkg::VOLT_TAB[i]} &&
          voltage_mv_i <= {{PAD_W{1'b0}}, bvp_pkg::VOLT_TAB[i+1]}) begin
        dec_d.seg = bvp_pkg::SEG_W'(i);
      end
    end
    diff     = voltage_mv_i - {{PAD_W{1'b0}}, bvp_pkg::VOLT_TAB[dec_d.seg]};
    dec_d.dv = diff[bvp_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_o       = dec_q;

endmodule

// ----- hdl/bvp_scale.sv -----
// Stage 2: scaled numerator, scaled base percent, whole percent
module bvp_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         dec_valid_i,
  input  bvp_pkg::dec_t                dec_i,
  input  logic [bvp_pkg::DIGITS_W-1:0] digits_i,
  output logic                         scl_valid_o,
  output bvp_pkg::scl_t                scl_o
);

  localparam int TDV_W = bvp_pkg::DEN_W + $clog2(bvp_pkg::PCT_STEP + 1);

  bvp_pkg::scl_t               scl_d, scl_q;
  logic                        valid_q;
  logic [bvp_pkg::TEN_M_W-1:0] ten_m;
  logic [bvp_pkg::SCALE_W-1:0] m;
  logic [bvp_pkg::DEN_W-1:0]   den;
  logic [TDV_W-1:0]            ten_dv;
  logic [bvp_pkg::PCT_W-1:0]   frac;

  always_comb begin
    ten_m  = bvp_pkg::TEN_M_TAB[digits_i];
    m      = bvp_pkg::SCALE_TAB[digits_i];
    den    = bvp_pkg::DEN_TAB[dec_i.seg];
    ten_dv = TDV_W'(dec_i.dv) * TDV_W'(bvp_pkg::PCT_STEP);

    // floor(dv * step / den) as a thermometer of independent compares
    frac = '0;
    for (int k = 1; k <= bvp_pkg::PCT_STEP; k++) begin
      if (ten_dv >= TDV_W'(k) * TDV_W'(den)) begin
        frac = bvp_pkg::PCT_W'(k);
      end
    end

    scl_d.sat_lo = dec_i.sat_lo;
    scl_d.sat_hi = dec_i.sat_hi;
    scl_d.seg    = dec_i.seg;
    scl_d.num    = bvp_pkg::NUM_W'(dec_i.dv) * bvp_pkg::NUM_W'(ten_m);
    scl_d.p1m    = bvp_pkg::P1M_W'(bvp_pkg::PCT_TAB[dec_i.seg]) * bvp_pkg::P1M_W'(m);
    if (dec_i.sat_lo) begin
      scl_d.whole = bvp_pkg::PCT_TAB[0];
    end else if (dec_i.sat_hi) begin
      scl_d.whole = bvp_pkg::PCT_TAB[bvp_pkg::TABLE_POINTS-1];
    end else begin
      scl_d.whole = bvp_pkg::PCT_TAB[dec_i.seg] + frac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_valid_i) begin
      scl_q <= scl_d;
    end
  end

  assign scl_valid_o = valid_q;
  assign scl_o       = scl_q;

endmodule

// ----- hdl/bvp_divide.sv -----
// Stages 3-4: num / den by reciprocal estimate, back-multiply, one correction
module bvp_divide (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      scl_valid_i,
  input  bvp_pkg::scl_t             scl_i,
  output logic                      quo_valid_o,
  output logic [bvp_pkg::QUO_W-1:0] quo_o,
  output bvp_pkg::tail_t            tail_o
);

  logic [bvp_pkg::PROD_W-1:0] prod;
  bvp_pkg::tail_t             tail_a_d;

  logic                       a_valid_q, b_valid_q;
  logic [bvp_pkg::QUO_W-1:0]  q0_a_q, q0_b_q;
  logic [bvp_pkg::NUM_W-1:0]  num_a_q, num_b_q;
  logic [bvp_pkg::DEN_W-1:0]  den_a_q, den_b_q;
  bvp_pkg::tail_t             tail_a_q, tail_b_q;
  logic [bvp_pkg::BACK_W-1:0] back_b_d, back_b_q;
  logic [bvp_pkg::NUM_W-1:0]  rem;

  always_comb begin
    prod = bvp_pkg::PROD_W'(scl_i.num) *
           bvp_pkg::PROD_W'(bvp_pkg::RECIP_TAB[scl_i.seg]);
    tail_a_d.sat_lo = scl_i.sat_lo;
    tail_a_d.sat_hi = scl_i.sat_hi;
    tail_a_d.p1m    = scl_i.p1m;
    tail_a_d.whole  = scl_i.whole;
  end

  assign back_b_d = bvp_pkg::BACK_W'(q0_a_q) * bvp_pkg::BACK_W'(den_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= scl_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scl_valid_i) begin
      q0_a_q   <= prod[bvp_pkg::RECIP_SHIFT +: bvp_pkg::QUO_W];
      num_a_q  <= scl_i.num;
      den_a_q  <= bvp_pkg::DEN_TAB[scl_i.seg];
      tail_a_q <= tail_a_d;
    end
    if (a_valid_q) begin
      back_b_q <= back_b_d;
      q0_b_q   <= q0_a_q;
      num_b_q  <= num_a_q;
      den_b_q  <= den_a_q;
      tail_b_q <= tail_a_q;
    end
  end

  // estimate is exact or one short
  assign rem         = num_b_q - bvp_pkg::NUM_W'(back_b_q);
  assign quo_o       = (rem >= bvp_pkg::NUM_W'(den_b_q)) ? q0_b_q + 1'b1 : q0_b_q;
  assign quo_valid_o = b_valid_q;
  assign tail_o      = tail_b_q;

endmodule

// ----- sim/battery_voltage_to_percent_tb.sv -----
`timescale 1ns / 100ps

module battery_voltage_to_percent_tb;

  // Sender bursts, gaps and the stall watchdog, in clock cycles
  localparam int MAX_BURST     = 40;
  localparam int MAX_GAP       = 6;
  localparam int IDLE_LIMIT    = 1000;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_PER_CFG = 73;
  localparam int N_CFG         = 8;

  // Discharge curve knees, kept apart from the design's own tables
  localparam int unsigned KNEE_MV [bvp_pkg::TABLE_POINTS] = '{
    3000, 3200, 3400, 3560, 3680, 3800, 3880, 3960, 4040, 4120, 4200
  };
  localparam int unsigned KNEE_PCT [bvp_pkg::TABLE_POINTS] = '{
    0, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100
  };

  // Register settings for the random part: both extremes of each register,
  // saturating digit counts and thresholds above one hundred among them
  localparam logic [bvp_pkg::DIGITS_W-1:0] DIGITS_PLAN [N_CFG] = '{
    3'd4, 3'd7, 3'd0, 3'd2, 3'd5, 3'd1, 3'd3, 3'd6
  };
  localparam logic [bvp_pkg::THR_W-1:0] THR_PLAN [N_CFG] = '{
    7'd0, 7'd127, 7'd100, 7'd101, 7'd50, 7'd1, 7'd37, 7'd99
  };

  // Directed voltages: field extremes, every knee, both sides of the clamps
  localparam int unsigned EDGE_MV [19] = '{
    0, 65535, 2999, 3000, 3001, 3200, 3400, 3560, 3680, 3800, 3880, 3960,
    4040, 4120, 4199, 4200, 4201, 3201, 3999
  };

  typedef struct packed {
    logic [bvp_pkg::OUT_W-1:0] percent_scaled;
    logic                      is_empty;
  } charge_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           start_i      = 1'b0;
  logic                           busy_o;
  logic [bvp_pkg::VOLT_W-1:0]     voltage_mv_i = '0;
  logic                           done_o;
  logic [bvp_pkg::OUT_W-1:0]      percent_scaled_o;
  logic                           is_empty_o;
  logic                           cfg_we_i     = 1'b0;
  bvp_pkg::cfg_reg_e              cfg_idx_i    = bvp_pkg::REG_FRACTION_DIGITS;
  logic [bvp_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;

  // Voltages waiting to go in, and the charge readings owed by the design
  logic [bvp_pkg::VOLT_W-1:0] voltage_queue [$];
  charge_t                    charge_due [$];

  // Register shadow, tracked from the write port
  logic [bvp_pkg::DIGITS_W-1:0] digits_shadow = bvp_pkg::DIGITS_RESET;
  logic [bvp_pkg::THR_W-1:0]    thr_shadow    = bvp_pkg::THR_RESET;

  logic sample_taken = 1'b0;
  int   burst_left   = 0;
  int   gap_left     = 0;
  int   idle_cycles  = 0;
  int   n_samples    = 0;
  int   n_readings   = 0;
  int   n_errors     = 0;

  battery_voltage_to_percent dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .voltage_mv_i     (voltage_mv_i),
    .done_o           (done_o),
    .percent_scaled_o (percent_scaled_o),
    .is_empty_o       (is_empty_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Piecewise linear charge estimate. Scale is ten to the digit count, the
  // count saturating at four; division truncates, as does the whole percent
  // used for the empty flag.
  function automatic charge_t predict_charge(input logic [bvp_pkg::VOLT_W-1:0] mv,
                                             input logic [bvp_pkg::DIGITS_W-1:0] digits,
                                             input logic [bvp_pkg::THR_W-1:0] thr);
    longint unsigned scale;
    longint unsigned scaled;
    longint unsigned v;
    charge_t         res;
    int              k;
    scale  = 1;
    scaled = 0;
    v      = mv;
    for (k = 0; k < ((digits > 3'd4) ? 4 : int'(digits)); k++) scale = scale * 10;
    if (v <= KNEE_MV[0]) begin
      scaled = KNEE_PCT[0] * scale;
    end else if (v >= KNEE_MV[bvp_pkg::TABLE_POINTS-1]) begin
      scaled = KNEE_PCT[bvp_pkg::TABLE_POINTS-1] * scale;
    end else begin
      for (k = 0; k < bvp_pkg::TABLE_POINTS - 1; k++) begin
        if (v > KNEE_MV[k] && v <= KNEE_MV[k+1]) begin
          scaled = (v - KNEE_MV[k]) * (KNEE_PCT[k+1] - KNEE_PCT[k]) * scale
                   / (KNEE_MV[k+1] - KNEE_MV[k]) + KNEE_PCT[k] * scale;
        end
      end
    end
    res.percent_scaled = scaled[bvp_pkg::OUT_W-1:0];
    res.is_empty       = ((scaled / scale) < thr);
    return res;
  endfunction

  // Register write, only ever issued with the pipeline empty
  task automatic write_reg(input bvp_pkg::cfg_reg_e idx,
                           input logic [bvp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Wait until every queued voltage has gone in and every reading is back
  task automatic drain;
    while (voltage_queue.size() != 0 || charge_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Driver: bursts of random length from the voltage queue, random gaps in
  // between (a gap of zero gives long back-to-back stretches). A beat that
  // was offered but not taken is held as it is.
  always @(negedge clk_i) begin
    if (start_i && !sample_taken) begin
      // hold the offered beat
    end else if (gap_left != 0) begin
      start_i  <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (voltage_queue.size() != 0) begin
      start_i      <= 1'b1;
      voltage_mv_i <= voltage_queue[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, MAX_BURST);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: tracks register writes and taken beats, checks each reading
  // against the oldest one owed, and watches for a stalled run.
  always @(posedge clk_i) begin : monitor
    charge_t due;
    if (rst_ni) begin
      sample_taken <= start_i && !busy_o;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          bvp_pkg::REG_FRACTION_DIGITS:
            digits_shadow <= cfg_data_i[bvp_pkg::DIGITS_W-1:0];
          bvp_pkg::REG_EMPTY_THRESHOLD:
            thr_shadow    <= cfg_data_i[bvp_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      if (done_o) begin
        n_readings++;
        if (charge_due.size() == 0) begin
          n_errors++;
          $display("%0t: reading with none owed: percent_scaled %0d is_empty %0b",
                   $time, percent_scaled_o, is_empty_o);
        end else begin
          due = charge_due.pop_front();
          if (percent_scaled_o !== due.percent_scaled) begin
            n_errors++;
            $display("%0t: percent_scaled expected %0d actual %0d",
                     $time, due.percent_scaled, percent_scaled_o);
          end
          if (is_empty_o !== due.is_empty) begin
            n_errors++;
            $display("%0t: is_empty expected %0b actual %0b",
                     $time, due.is_empty, is_empty_o);
          end
        end
      end

      if (start_i && !busy_o) begin
        charge_due.push_back(predict_charge(voltage_mv_i, digits_shadow, thr_shadow));
        void'(voltage_queue.pop_front());
        n_samples++;
      end

      if ((start_i && !busy_o) || done_o || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d readings still owed",
                 $time, IDLE_LIMIT, charge_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus: directed voltages at the reset settings, then random voltages
  // under each planned register setting, drained before every write
  initial begin
    int ph;
    int i;
    int knee;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (EDGE_MV[j]) voltage_queue.push_back(EDGE_MV[j][bvp_pkg::VOLT_W-1:0]);
    drain();

    for (ph = 0; ph < N_CFG; ph++) begin
      write_reg(bvp_pkg::REG_FRACTION_DIGITS, bvp_pkg::CFG_DATA_W'(DIGITS_PLAN[ph]));
      write_reg(bvp_pkg::REG_EMPTY_THRESHOLD, bvp_pkg::CFG_DATA_W'(THR_PLAN[ph]));
      for (i = 0; i < RANDOM_PER_CFG; i++) begin
        case ($urandom_range(0, 9))
          0, 1: voltage_queue.push_back(bvp_pkg::VOLT_W'($urandom));
          2: begin
            // close to a knee, either side
            knee = KNEE_MV[$urandom_range(0, bvp_pkg::TABLE_POINTS - 1)]
                   + $urandom_range(0, 4) - 2;
            voltage_queue.push_back(bvp_pkg::VOLT_W'(knee));
          end
          default: voltage_queue.push_back(bvp_pkg::VOLT_W'($urandom_range(2950, 4250)));
        endcase
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (charge_due.size() != 0) n_errors++;

    $display("Checked %0d readings from %0d voltage samples over %0d register settings",
             n_readings, n_samples, N_CFG + 1);
    $display("(digit counts 0 to 7, empty thresholds 0 to 127, full 16-bit voltage span)");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
